// ===== hdl/farr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farr_pkg: shared definitions for the fading additive ray rasterizer
// Frame geometry, field widths, command and register codes, and the
// request/status structs of the shared serial divider.
// ----------------------------------------------------------------------------
package farr_pkg;

   // frame store geometry
   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 128;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int X_IDX_W     = $clog2(MAX_WIDTH);
   localparam int Y_IDX_W     = $clog2(MAX_HEIGHT);
   localparam int EFF_W_W     = $clog2(MAX_WIDTH + 1);
   localparam int EFF_H_W     = $clog2(MAX_HEIGHT + 1);

   // field widths
   localparam int CMD_W       = 2;
   localparam int COORD_W     = 11;
   localparam int COLOR_W     = 16;
   localparam int INTENSITY_W = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;

   // 12.16 stepping
   localparam int FRAC_W  = 16;
   localparam int FP_W    = COORD_W + FRAC_W + 1;
   localparam int STEP_W  = FRAC_W + 2;
   localparam int ALPHA_W = INTENSITY_W + 8;

   // shared divider
   localparam int DIV_NUM_W = COORD_W + FRAC_W;
   localparam int DIV_DEN_W = COORD_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // RGB565 channel limits and rounding
   localparam int CH5_MAX     = 31;
   localparam int CH6_MAX     = 63;
   localparam int BLEND_ROUND = 128;

   // commands
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RAY   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_HEIGHT = 1'd1;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numerator;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hdl/farr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farr_div: restoring serial divider
// One quotient bit per cycle; done is high for a single cycle, in the same cycle the full quotient shows.
// ----------------------------------------------------------------------------
module farr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  farr_pkg::div_req_type          req,
   output farr_pkg::div_stat_type         stat,
   output logic [farr_pkg::DIV_NUM_W-1:0] quotient
);

   logic [farr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [farr_pkg::DIV_NUM_W-1:0] work_ff, work_in;
   logic [farr_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [farr_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [farr_pkg::DIV_DEN_W:0]   rem_sh;
   logic [farr_pkg::DIV_DEN_W:0]   rem_sub;
   logic                           fits;

   assign rem_sh  = {rem_ff, work_ff[farr_pkg::DIV_NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         cnt_in  = farr_pkg::DIV_CNT_W'(farr_pkg::DIV_NUM_W);
         work_in = req.numerator;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == farr_pkg::DIV_CNT_W'(1));
         work_in = {work_ff[farr_pkg::DIV_NUM_W-2:0], fits};
         rem_in  = fits ? rem_sub[farr_pkg::DIV_DEN_W-1:0]
                        : rem_sh[farr_pkg::DIV_DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = work_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> cnt_ff == '0)
      else $error("divider restarted while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> cnt_ff == '0 || $past(req.start))
      else $error("divider done while still stepping");
   a_last_bit: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == farr_pkg::DIV_CNT_W'(1) && !req.start) |=> done_ff)
      else $error("divider missed done after last bit");
`endif

endmodule

// ===== hdl/fading_additive_ray_raster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fading_additive_ray_raster: RGB565 frame store with pixel access and rays
// Writes and reads single pixels and draws fading rays that are added onto
// the frame with per-channel saturation, stepping a 12.16 DDA.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   ------------------------  ---------------------------------------
//  request   start & !busy -> transfer req_command, req_x/y_start, req_x/y_end,
//                                      req_color, req_intensity
//  response  rsp_valid, one cycle      rsp_read_data, rsp_in_range
//  csr       csr_write, no wait        csr_index, csr_data
//
//  A pixel read goes through the registered store read. A ray with
//  len = max(|dx|,|dy|) > 0 runs three passes of the serial divider and
//  then steps its len+1 pixels one at a time through the frame store.
//  Zero-length rays and unused commands are answered from decode.
//  Reset clears the sequencer, the response strobe and the two size
//  registers (to 128); the frame store itself is not cleared.
//  The response cannot be stalled; busy stays high until the cycle the
//  response strobe shows.
// ----------------------------------------------------------------------------
module fading_additive_ray_raster (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             start,
   output logic                             busy,
   input  logic [farr_pkg::CMD_W-1:0]       req_command,
   input  logic [farr_pkg::COORD_W-1:0]     req_x_start,
   input  logic [farr_pkg::COORD_W-1:0]     req_y_start,
   input  logic [farr_pkg::COORD_W-1:0]     req_x_end,
   input  logic [farr_pkg::COORD_W-1:0]     req_y_end,
   input  logic [farr_pkg::COLOR_W-1:0]     req_color,
   input  logic [farr_pkg::INTENSITY_W-1:0] req_intensity,
   // response
   output logic                             rsp_valid,
   output logic [farr_pkg::COLOR_W-1:0]     rsp_read_data,
   output logic                             rsp_in_range,
   // configuration
   input  logic                             csr_write,
   input  logic [farr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [farr_pkg::CSR_DATA_W-1:0]  csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECODE  = 3'd1;
   localparam logic [2:0] ST_RD_WAIT = 3'd2;
   localparam logic [2:0] ST_DIV_X   = 3'd3;
   localparam logic [2:0] ST_DIV_Y   = 3'd4;
   localparam logic [2:0] ST_DIV_A   = 3'd5;
   localparam logic [2:0] ST_PIX     = 3'd6;
   localparam logic [2:0] ST_BLEND   = 3'd7;

   localparam int XI_W = farr_pkg::COORD_W + 1;   // integer part of a DDA position

   logic [2:0] state_ff, state_in;

   // latched request
   logic [farr_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [farr_pkg::COORD_W-1:0]     xs_ff, xs_in;
   logic [farr_pkg::COORD_W-1:0]     ys_ff, ys_in;
   logic [farr_pkg::COORD_W-1:0]     xe_ff, xe_in;
   logic [farr_pkg::COORD_W-1:0]     ye_ff, ye_in;
   logic [farr_pkg::COLOR_W-1:0]     color_ff, color_in;
   logic [farr_pkg::INTENSITY_W-1:0] intensity_ff, intensity_in;

   // ray setup and DDA state
   logic [farr_pkg::COORD_W-1:0]       len_ff, len_in;
   logic [farr_pkg::COORD_W-1:0]       ady_ff, ady_in;
   logic                               negx_ff, negx_in;
   logic                               negy_ff, negy_in;
   logic signed [farr_pkg::STEP_W-1:0] sx_ff, sx_in;
   logic signed [farr_pkg::STEP_W-1:0] sy_ff, sy_in;
   logic signed [farr_pkg::FP_W-1:0]   xf_ff, xf_in;
   logic signed [farr_pkg::FP_W-1:0]   yf_ff, yf_in;
   logic [farr_pkg::ALPHA_W-1:0]       alpha_ff, alpha_in;
   logic [farr_pkg::ALPHA_W-1:0]       step_ff, step_in;
   logic [farr_pkg::COORD_W-1:0]       idx_ff, idx_in;
   logic [farr_pkg::ADDR_W-1:0]        addr_ff, addr_in;

   // response
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [farr_pkg::COLOR_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_in_range_ff, rsp_in_range_in;

   // size registers
   logic [farr_pkg::CSR_DATA_W-1:0] width_ff;
   logic [farr_pkg::CSR_DATA_W-1:0] height_ff;
   logic [farr_pkg::EFF_W_W-1:0]    eff_w;
   logic [farr_pkg::EFF_H_W-1:0]    eff_h;

   // frame store
   logic [farr_pkg::COLOR_W-1:0] frame_mem [farr_pkg::STORE_DEPTH];
   logic [farr_pkg::COLOR_W-1:0] rd_data_ff;
   logic                         mem_we;
   logic [farr_pkg::ADDR_W-1:0]  mem_waddr;
   logic [farr_pkg::COLOR_W-1:0] mem_wdata;

   // divider
   farr_pkg::div_req_type          div_req;
   farr_pkg::div_stat_type         div_stat;
   logic [farr_pkg::DIV_NUM_W-1:0] div_quot;
   logic [farr_pkg::STEP_W-1:0]    q_mag;

   // pixel position, area test and address (shared by commands and rays)
   logic [XI_W-1:0]             px_x, px_y;
   logic                        px_inside;
   logic [farr_pkg::ADDR_W-1:0] px_addr;

   // ray setup
   logic [XI_W-1:0]              dx, dy, adx, ady;
   logic [farr_pkg::COORD_W-1:0] len_c;

   // blend datapath
   logic [7:0]  alpha8;
   logic [4:0]  d_r, d_b, s_r, s_b;
   logic [5:0]  d_g, s_g;
   logic [14:0] p_r, p_g, p_b;
   logic [6:0]  t_r, t_g, t_b;
   logic [4:0]  o_r, o_b;
   logic [5:0]  o_g;
   logic [farr_pkg::COLOR_W-1:0] blend_px;

   // step bookkeeping
   logic [farr_pkg::ALPHA_W-1:0] alpha_adv;
   logic                         last_px;

   farr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // sizes saturate at the store geometry
   assign eff_w = (32'(width_ff) > farr_pkg::MAX_WIDTH)
                ? farr_pkg::EFF_W_W'(farr_pkg::MAX_WIDTH) : farr_pkg::EFF_W_W'(width_ff);
   assign eff_h = (32'(height_ff) > farr_pkg::MAX_HEIGHT)
                ? farr_pkg::EFF_H_W'(farr_pkg::MAX_HEIGHT) : farr_pkg::EFF_H_W'(height_ff);

   // in PIX the position comes from the DDA, otherwise from the request
   always_comb begin
      if (state_ff == ST_PIX) begin
         px_x = xf_ff[farr_pkg::FP_W-1:farr_pkg::FRAC_W];
         px_y = yf_ff[farr_pkg::FP_W-1:farr_pkg::FRAC_W];
      end else begin
         px_x = {xs_ff[farr_pkg::COORD_W-1], xs_ff};
         px_y = {ys_ff[farr_pkg::COORD_W-1], ys_ff};
      end
   end

   assign px_inside = !px_x[XI_W-1] && !px_y[XI_W-1]
                    && (32'(px_x[XI_W-2:0]) < 32'(eff_w))
                    && (32'(px_y[XI_W-2:0]) < 32'(eff_h));

   assign px_addr = farr_pkg::ADDR_W'(px_y[farr_pkg::Y_IDX_W-1:0])
                  * farr_pkg::ADDR_W'(eff_w)
                  + farr_pkg::ADDR_W'(px_x[farr_pkg::X_IDX_W-1:0]);

   // ray length is the larger axis delta
   assign dx    = {xe_ff[farr_pkg::COORD_W-1], xe_ff} - {xs_ff[farr_pkg::COORD_W-1], xs_ff};
   assign dy    = {ye_ff[farr_pkg::COORD_W-1], ye_ff} - {ys_ff[farr_pkg::COORD_W-1], ys_ff};
   assign adx   = dx[XI_W-1] ? (~dx + 1'b1) : dx;
   assign ady   = dy[XI_W-1] ? (~dy + 1'b1) : dy;
   assign len_c = (adx > ady) ? adx[farr_pkg::COORD_W-1:0] : ady[farr_pkg::COORD_W-1:0];

   // step magnitude never exceeds one whole pixel
   assign q_mag = {1'b0, div_quot[farr_pkg::FRAC_W:0]};

   // additive blend with rounding and per-channel saturation
   assign alpha8 = alpha_ff[farr_pkg::ALPHA_W-1:8];
   assign d_r    = rd_data_ff[15:11];
   assign d_g    = rd_data_ff[10:5];
   assign d_b    = rd_data_ff[4:0];
   assign s_r    = color_ff[15:11];
   assign s_g    = color_ff[10:5];
   assign s_b    = color_ff[4:0];
   assign p_r    = 15'(s_r) * 15'(alpha8) + 15'(farr_pkg::BLEND_ROUND);
   assign p_g    = 15'(s_g) * 15'(alpha8) + 15'(farr_pkg::BLEND_ROUND);
   assign p_b    = 15'(s_b) * 15'(alpha8) + 15'(farr_pkg::BLEND_ROUND);
   assign t_r    = 7'(d_r) + 7'(p_r[14:8]);
   assign t_g    = 7'(d_g) + 7'(p_g[14:8]);
   assign t_b    = 7'(d_b) + 7'(p_b[14:8]);
   assign o_r    = (t_r > 7'(farr_pkg::CH5_MAX)) ? 5'(farr_pkg::CH5_MAX) : t_r[4:0];
   assign o_g    = (t_g > 7'(farr_pkg::CH6_MAX)) ? 6'(farr_pkg::CH6_MAX) : t_g[5:0];
   assign o_b    = (t_b > 7'(farr_pkg::CH5_MAX)) ? 5'(farr_pkg::CH5_MAX) : t_b[4:0];
   assign blend_px = {o_r, o_g, o_b};

   // alpha fades after every fourth pixel while it stays above the step
   assign alpha_adv = (idx_ff[1:0] == 2'd0 && alpha_ff > step_ff)
                    ? alpha_ff - step_ff : alpha_ff;
   assign last_px   = (idx_ff == len_ff);

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      xs_in           = xs_ff;
      ys_in           = ys_ff;
      xe_in           = xe_ff;
      ye_in           = ye_ff;
      color_in        = color_ff;
      intensity_in    = intensity_ff;
      len_in          = len_ff;
      ady_in          = ady_ff;
      negx_in         = negx_ff;
      negy_in         = negy_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      xf_in           = xf_ff;
      yf_in           = yf_ff;
      alpha_in        = alpha_ff;
      step_in         = step_ff;
      idx_in          = idx_ff;
      addr_in         = addr_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = '0;
      rsp_in_range_in = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = addr_ff;
      mem_wdata       = blend_px;
      div_req.start     = 1'b0;
      div_req.numerator = '0;
      div_req.divisor   = len_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in       = req_command;
               xs_in        = req_x_start;
               ys_in        = req_y_start;
               xe_in        = req_x_end;
               ye_in        = req_y_end;
               color_in     = req_color;
               intensity_in = req_intensity;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (cmd_ff)
               farr_pkg::CMD_WRITE: begin
                  mem_we          = px_inside;
                  mem_waddr       = px_addr;
                  mem_wdata       = color_ff;
                  rsp_valid_in    = 1'b1;
                  rsp_in_range_in = px_inside;
                  state_in        = ST_IDLE;
               end
               farr_pkg::CMD_READ: begin
                  // store read issued at px_addr this cycle
                  if (px_inside) begin
                     state_in = ST_RD_WAIT;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               farr_pkg::CMD_RAY: begin
                  len_in  = len_c;
                  ady_in  = ady[farr_pkg::COORD_W-1:0];
                  negx_in = dx[XI_W-1];
                  negy_in = dy[XI_W-1];
                  if (len_c == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     div_req.start     = 1'b1;
                     div_req.numerator = {adx[farr_pkg::COORD_W-1:0],
                                          {farr_pkg::FRAC_W{1'b0}}};
                     div_req.divisor   = len_c;
                     state_in          = ST_DIV_X;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_RD_WAIT: begin
            rsp_valid_in    = 1'b1;
            rsp_data_in     = rd_data_ff;
            rsp_in_range_in = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_DIV_X: begin
            if (div_stat.done) begin
               sx_in             = negx_ff ? (~q_mag + 1'b1) : q_mag;
               div_req.start     = 1'b1;
               div_req.numerator = {ady_ff, {farr_pkg::FRAC_W{1'b0}}};
               state_in          = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_stat.done) begin
               sy_in             = negy_ff ? (~q_mag + 1'b1) : q_mag;
               div_req.start     = 1'b1;
               div_req.numerator = farr_pkg::DIV_NUM_W'({intensity_ff, 8'd0});
               state_in          = ST_DIV_A;
            end
         end
         ST_DIV_A: begin
            if (div_stat.done) begin
               step_in  = div_quot[farr_pkg::ALPHA_W-1:0];
               alpha_in = {intensity_ff, 8'd0};
               xf_in    = farr_pkg::FP_W'($signed({xs_ff, {farr_pkg::FRAC_W{1'b0}}}));
               yf_in    = farr_pkg::FP_W'($signed({ys_ff, {farr_pkg::FRAC_W{1'b0}}}));
               idx_in   = '0;
               state_in = ST_PIX;
            end
         end
         ST_PIX: begin
            // store read issued at px_addr; off-area pixels just advance
            addr_in = px_addr;
            if (px_inside) begin
               state_in = ST_BLEND;
            end else begin
               alpha_in = alpha_adv;
               xf_in    = xf_ff + farr_pkg::FP_W'(sx_ff);
               yf_in    = yf_ff + farr_pkg::FP_W'(sy_ff);
               idx_in   = idx_ff + 1'b1;
               if (last_px) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_BLEND: begin
            mem_we   = (alpha8 != 8'd0);
            alpha_in = alpha_adv;
            xf_in    = xf_ff + farr_pkg::FP_W'(sx_ff);
            yf_in    = yf_ff + farr_pkg::FP_W'(sy_ff);
            idx_in   = idx_ff + 1'b1;
            if (last_px) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_PIX;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         rsp_data_ff     <= '0;
         rsp_in_range_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_data_ff     <= rsp_data_in;
         rsp_in_range_ff <= rsp_in_range_in;
      end
      cmd_ff       <= cmd_in;
      xs_ff        <= xs_in;
      ys_ff        <= ys_in;
      xe_ff        <= xe_in;
      ye_ff        <= ye_in;
      color_ff     <= color_in;
      intensity_ff <= intensity_in;
      len_ff       <= len_in;
      ady_ff       <= ady_in;
      negx_ff      <= negx_in;
      negy_ff      <= negy_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      xf_ff        <= xf_in;
      yf_ff        <= yf_in;
      alpha_ff     <= alpha_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      addr_ff      <= addr_in;
   end

   // size registers: the user writes them only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= farr_pkg::CSR_DATA_W'(farr_pkg::MAX_WIDTH);
         height_ff <= farr_pkg::CSR_DATA_W'(farr_pkg::MAX_HEIGHT);
      end else if (csr_write) begin
         unique case (csr_index)
            farr_pkg::CSR_ACTIVE_WIDTH:  width_ff  <= csr_data;
            farr_pkg::CSR_ACTIVE_HEIGHT: height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= frame_mem[px_addr];
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_in_range  = rsp_in_range_ff;

`ifndef ASSERT_OFF
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("response shown while sequencer still busy");
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == ST_DECODE)
      else $error("accepted transfer not decoded");
   a_blend_after_pix: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLEND |-> $past(state_ff) == ST_PIX)
      else $error("blend without a pixel read");
   a_hit_only_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_in_range_ff)
         |-> (cmd_ff == farr_pkg::CMD_WRITE || cmd_ff == farr_pkg::CMD_READ))
      else $error("in_range set on a ray or unused command");
   a_pix_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PIX |-> !div_stat.busy)
      else $error("stepping pixels while divider busy");
`endif

endmodule
